>>> src/ovbb_pkg.sv
// ----------------------------------------------------------------------------
// ovbb_pkg
// Shared widths, step codes, register indexes and types of the bounding box.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ovbb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QUAT_W        = 18;
    localparam int COORD_W       = 32;
    localparam int HALF_W        = 31;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int STEP_W        = 5;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROT_W   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Y   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Z   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z = 3'd6;

    // sequencer steps: quaternion products
    localparam logic [STEP_W-1:0] STEP_XX = 5'd0;
    localparam logic [STEP_W-1:0] STEP_YY = 5'd1;
    localparam logic [STEP_W-1:0] STEP_ZZ = 5'd2;
    localparam logic [STEP_W-1:0] STEP_XY = 5'd3;
    localparam logic [STEP_W-1:0] STEP_XZ = 5'd4;
    localparam logic [STEP_W-1:0] STEP_YZ = 5'd5;
    localparam logic [STEP_W-1:0] STEP_WX = 5'd6;
    localparam logic [STEP_W-1:0] STEP_WY = 5'd7;
    localparam logic [STEP_W-1:0] STEP_WZ = 5'd8;
    // matrix build, row products, rounding, scaling, bounds, finish
    localparam logic [STEP_W-1:0] STEP_MATRIX = 5'd10;
    localparam logic [STEP_W-1:0] STEP_M00    = 5'd11;
    localparam logic [STEP_W-1:0] STEP_M01    = 5'd12;
    localparam logic [STEP_W-1:0] STEP_M02    = 5'd13;
    localparam logic [STEP_W-1:0] STEP_M10    = 5'd14;
    localparam logic [STEP_W-1:0] STEP_M11    = 5'd15;
    localparam logic [STEP_W-1:0] STEP_M12    = 5'd16;
    localparam logic [STEP_W-1:0] STEP_M20    = 5'd17;
    localparam logic [STEP_W-1:0] STEP_M21    = 5'd18;
    localparam logic [STEP_W-1:0] STEP_M22    = 5'd19;
    localparam logic [STEP_W-1:0] STEP_ROUND  = 5'd21;
    localparam logic [STEP_W-1:0] STEP_SX     = 5'd22;
    localparam logic [STEP_W-1:0] STEP_SY     = 5'd23;
    localparam logic [STEP_W-1:0] STEP_SZ     = 5'd24;
    localparam logic [STEP_W-1:0] STEP_BOUNDS = 5'd26;
    localparam logic [STEP_W-1:0] STEP_FINISH = 5'd27;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic              accept;
        logic              run;
        logic [STEP_W-1:0] step;
        logic              finish;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_stat;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

>>> src/ovbb_if.sv
// ----------------------------------------------------------------------------
// ovbb_if
// Valid/ready channels for vertices, boxes and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ovbb_vert_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [ovbb_pkg::COORD_W-1:0]     vert_x;
    logic signed [ovbb_pkg::COORD_W-1:0]     vert_y;
    logic signed [ovbb_pkg::COORD_W-1:0]     vert_z;
    logic                                    last_vertex;
    modport source (output valid, vert_x, vert_y, vert_z, last_vertex, input ready);
    modport sink   (input valid, vert_x, vert_y, vert_z, last_vertex, output ready);
endinterface

interface ovbb_box_if;
    logic                                valid;
    logic                                ready;
    logic signed [ovbb_pkg::COORD_W-1:0] centre_x;
    logic signed [ovbb_pkg::COORD_W-1:0] centre_y;
    logic signed [ovbb_pkg::COORD_W-1:0] centre_z;
    logic [ovbb_pkg::HALF_W-1:0]         half_x;
    logic [ovbb_pkg::HALF_W-1:0]         half_y;
    logic [ovbb_pkg::HALF_W-1:0]         half_z;
    modport source (output valid, centre_x, centre_y, centre_z, half_x, half_y, half_z,
                    input ready);
    modport sink   (input valid, centre_x, centre_y, centre_z, half_x, half_y, half_z,
                    output ready);
endinterface

interface ovbb_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ovbb_pkg::CFG_IDX_W-1:0]    index;
    logic [ovbb_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/oriented_vertex_bounding_box.sv
// ----------------------------------------------------------------------------
// oriented_vertex_bounding_box
// Axis-aligned box of vertices rotated by a quaternion and scaled per axis.
// ----------------------------------------------------------------------------
// The block takes a new vertex only once it is done with the last one:
// every multiplication (nine quaternion products, nine matrix-by-vertex
// products and three scale products) goes through one shared 32x32
// multiplier, one per cycle, with separate steps for the matrix build, rounding,
// the bounds update and the finish. A box waits in its own output register,
// so the next vertex is taken while it is unread; only the last vertex of the
// following model waits for it to be taken. Configuration writes are always
// ready and are to be made while no vertex is in flight.
`timescale 1ns / 1ps

module oriented_vertex_bounding_box #(
    parameter int FRAC_BITS = ovbb_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ovbb_cfg_if.sink     i_cfg,
    ovbb_vert_if.sink    i_vert,
    ovbb_box_if.source   o_box
);

    ovbb_pkg::t_cmd  w_cmd;
    ovbb_pkg::t_stat w_stat;

    assign i_cfg.ready = 1'b1;

    // sequencer
    ovbb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_vert.valid),
        .o_in_ready  (i_vert.ready),
        .o_out_valid (o_box.valid),
        .i_out_ready (o_box.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // arithmetic and storage
    ovbb_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_vert_x      (i_vert.vert_x),
        .i_vert_y      (i_vert.vert_y),
        .i_vert_z      (i_vert.vert_z),
        .i_last_vertex (i_vert.last_vertex),
        .o_centre_x    (o_box.centre_x),
        .o_centre_y    (o_box.centre_y),
        .o_centre_z    (o_box.centre_z),
        .o_half_x      (o_box.half_x),
        .o_half_y      (o_box.half_y),
        .o_half_z      (o_box.half_z)
    );

endmodule

>>> src/ovbb_ctrl.sv
// ----------------------------------------------------------------------------
// ovbb_ctrl
// Sequencer that steps the datapath through one vertex and owns the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ovbb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  ovbb_pkg::t_stat      i_stat,
    output ovbb_pkg::t_cmd       o_cmd
);

    ovbb_pkg::t_state                r_state, n_state;
    logic [ovbb_pkg::STEP_W-1:0]     r_step, n_step;
    logic                            r_out_valid, n_out_valid;
    logic                            w_at_end;
    logic                            w_finish;

    // finish waits only when a box must be loaded over an untaken one
    assign w_at_end = (r_state == ovbb_pkg::ST_RUN) && (r_step == ovbb_pkg::STEP_FINISH);
    assign w_finish = w_at_end && (!i_stat.last || !r_out_valid || i_out_ready);

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ovbb_pkg::ST_IDLE: begin
                n_step = '0;
                if (i_in_valid) begin
                    n_state = ovbb_pkg::ST_RUN;
                end
            end
            ovbb_pkg::ST_RUN: begin
                if (w_at_end) begin
                    if (w_finish) begin
                        n_state = ovbb_pkg::ST_IDLE;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            default: n_state = ovbb_pkg::ST_IDLE;
        endcase
    end

    // result flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_finish && i_stat.last) begin
            n_out_valid = 1'b1;
        end
    end

    // outputs
    always_comb begin
        o_in_ready   = (r_state == ovbb_pkg::ST_IDLE);
        o_cmd.accept = (r_state == ovbb_pkg::ST_IDLE) && i_in_valid;
        o_cmd.run    = (r_state == ovbb_pkg::ST_RUN);
        o_cmd.step   = r_step;
        o_cmd.finish = w_finish;
        o_out_valid  = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ovbb_pkg::ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> src/ovbb_datapath.sv
// ----------------------------------------------------------------------------
// ovbb_datapath
// Registers, one shared multiplier, matrix build, rounding and bounds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ovbb_datapath #(
    parameter int FRAC_BITS = ovbb_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ovbb_pkg::t_cmd                        i_cmd,
    output ovbb_pkg::t_stat                       o_stat,
    input  logic                                  i_cfg_we,
    input  logic [ovbb_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ovbb_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic signed [ovbb_pkg::COORD_W-1:0]   i_vert_x,
    input  logic signed [ovbb_pkg::COORD_W-1:0]   i_vert_y,
    input  logic signed [ovbb_pkg::COORD_W-1:0]   i_vert_z,
    input  logic                                  i_last_vertex,
    output logic signed [ovbb_pkg::COORD_W-1:0]   o_centre_x,
    output logic signed [ovbb_pkg::COORD_W-1:0]   o_centre_y,
    output logic signed [ovbb_pkg::COORD_W-1:0]   o_centre_z,
    output logic [ovbb_pkg::HALF_W-1:0]           o_half_x,
    output logic [ovbb_pkg::HALF_W-1:0]           o_half_y,
    output logic [ovbb_pkg::HALF_W-1:0]           o_half_z
);

    localparam int CW = ovbb_pkg::COORD_W;
    localparam int QW = ovbb_pkg::QUAT_W;
    localparam int PW = 2 * QW;
    localparam int MS = 2 * (QW - 2) - FRAC_BITS;
    localparam int MW = FRAC_BITS + 6;
    localparam int EW = 40;
    localparam logic signed [EW-1:0] ONE      = 40'sd1 <<< (2 * (QW - 2));
    localparam logic signed [EW-1:0] M_HALF   = 40'sd1 <<< (MS - 1);
    localparam logic signed [63:0]   F_HALF   = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [CW-1:0] UNIT     = 32'sd1 <<< FRAC_BITS;

    // configuration
    logic signed [QW-1:0] r_rot_w, r_rot_x, r_rot_y, r_rot_z;
    logic signed [CW-1:0] r_scale [3];

    // item and working registers
    logic signed [CW-1:0] r_v [3];
    logic                 r_last;
    logic signed [PW-1:0] r_q [9];
    logic signed [MW-1:0] r_m [9];
    logic signed [63:0]   r_acc [3];
    logic signed [CW-1:0] r_r [3];
    logic signed [CW-1:0] r_t [3];
    logic signed [CW-1:0] r_lo [3];
    logic signed [CW-1:0] r_hi [3];
    logic                 r_seen;
    logic signed [63:0]   r_prod;
    logic [ovbb_pkg::STEP_W-1:0] r_ptag;
    logic                 r_pvalid;

    logic signed [CW-1:0] w_a, w_b;
    logic                 w_issue;
    logic signed [EW-1:0] w_e [9];
    logic signed [MW-1:0] w_m [9];
    logic signed [63:0]   w_prod_rnd;
    logic signed [CW-1:0] w_centre [3];
    logic [ovbb_pkg::HALF_W-1:0] w_half [3];

    assign o_stat.last = r_last;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_w    <= 18'sd65536;
            r_rot_x    <= '0;
            r_rot_y    <= '0;
            r_rot_z    <= '0;
            r_scale[0] <= UNIT;
            r_scale[1] <= UNIT;
            r_scale[2] <= UNIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ovbb_pkg::REG_ROT_W:   r_rot_w    <= i_cfg_data[QW-1:0];
                ovbb_pkg::REG_ROT_X:   r_rot_x    <= i_cfg_data[QW-1:0];
                ovbb_pkg::REG_ROT_Y:   r_rot_y    <= i_cfg_data[QW-1:0];
                ovbb_pkg::REG_ROT_Z:   r_rot_z    <= i_cfg_data[QW-1:0];
                ovbb_pkg::REG_SCALE_X: r_scale[0] <= i_cfg_data;
                ovbb_pkg::REG_SCALE_Y: r_scale[1] <= i_cfg_data;
                ovbb_pkg::REG_SCALE_Z: r_scale[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // multiplier operand select by step
    always_comb begin
        w_a     = '0;
        w_b     = '0;
        w_issue = i_cmd.run;
        case (i_cmd.step)
            ovbb_pkg::STEP_XX: begin w_a = CW'(r_rot_x); w_b = CW'(r_rot_x); end
            ovbb_pkg::STEP_YY: begin w_a = CW'(r_rot_y); w_b = CW'(r_rot_y); end
            ovbb_pkg::STEP_ZZ: begin w_a = CW'(r_rot_z); w_b = CW'(r_rot_z); end
            ovbb_pkg::STEP_XY: begin w_a = CW'(r_rot_x); w_b = CW'(r_rot_y); end
            ovbb_pkg::STEP_XZ: begin w_a = CW'(r_rot_x); w_b = CW'(r_rot_z); end
            ovbb_pkg::STEP_YZ: begin w_a = CW'(r_rot_y); w_b = CW'(r_rot_z); end
            ovbb_pkg::STEP_WX: begin w_a = CW'(r_rot_w); w_b = CW'(r_rot_x); end
            ovbb_pkg::STEP_WY: begin w_a = CW'(r_rot_w); w_b = CW'(r_rot_y); end
            ovbb_pkg::STEP_WZ: begin w_a = CW'(r_rot_w); w_b = CW'(r_rot_z); end
            ovbb_pkg::STEP_M00: begin w_a = CW'(r_m[0]); w_b = r_v[0]; end
            ovbb_pkg::STEP_M01: begin w_a = CW'(r_m[1]); w_b = r_v[1]; end
            ovbb_pkg::STEP_M02: begin w_a = CW'(r_m[2]); w_b = r_v[2]; end
            ovbb_pkg::STEP_M10: begin w_a = CW'(r_m[3]); w_b = r_v[0]; end
            ovbb_pkg::STEP_M11: begin w_a = CW'(r_m[4]); w_b = r_v[1]; end
            ovbb_pkg::STEP_M12: begin w_a = CW'(r_m[5]); w_b = r_v[2]; end
            ovbb_pkg::STEP_M20: begin w_a = CW'(r_m[6]); w_b = r_v[0]; end
            ovbb_pkg::STEP_M21: begin w_a = CW'(r_m[7]); w_b = r_v[1]; end
            ovbb_pkg::STEP_M22: begin w_a = CW'(r_m[8]); w_b = r_v[2]; end
            ovbb_pkg::STEP_SX:  begin w_a = r_r[0]; w_b = r_scale[0]; end
            ovbb_pkg::STEP_SY:  begin w_a = r_r[1]; w_b = r_scale[1]; end
            ovbb_pkg::STEP_SZ:  begin w_a = r_r[2]; w_b = r_scale[2]; end
            default: w_issue = 1'b0;
        endcase
    end

    // shared multiplier, product tagged with its step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else begin
            r_pvalid <= w_issue;
        end
        r_prod <= w_a * w_b;
        r_ptag <= i_cmd.step;
    end

    // rotation matrix entries at full precision, then rounded
    always_comb begin
        w_e[0] = ONE - 2 * (EW'(r_q[1]) + EW'(r_q[2]));
        w_e[1] = 2 * (EW'(r_q[3]) - EW'(r_q[8]));
        w_e[2] = 2 * (EW'(r_q[4]) + EW'(r_q[7]));
        w_e[3] = 2 * (EW'(r_q[3]) + EW'(r_q[8]));
        w_e[4] = ONE - 2 * (EW'(r_q[0]) + EW'(r_q[2]));
        w_e[5] = 2 * (EW'(r_q[5]) - EW'(r_q[6]));
        w_e[6] = 2 * (EW'(r_q[4]) - EW'(r_q[7]));
        w_e[7] = 2 * (EW'(r_q[5]) + EW'(r_q[6]));
        w_e[8] = ONE - 2 * (EW'(r_q[0]) + EW'(r_q[1]));
        for (int k = 0; k < 9; k++) begin
            w_m[k] = MW'((w_e[k] + M_HALF) >>> MS);
        end
    end

    assign w_prod_rnd = (r_prod + F_HALF) >>> FRAC_BITS;

    // centre and half extent from the bounds
    always_comb begin
        logic signed [CW:0] sum;
        logic signed [CW:0] h;
        for (int k = 0; k < 3; k++) begin
            sum         = (CW+1)'(r_lo[k]) + (CW+1)'(r_hi[k]);
            w_centre[k] = CW'(sum >>> 1);
            h           = (CW+1)'(r_hi[k]) - (CW+1)'(w_centre[k]);
            if (h > (CW+1)'(33'sh0_7FFF_FFFF)) begin
                w_half[k] = '1;
            end else begin
                w_half[k] = h[ovbb_pkg::HALF_W-1:0];
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_v[0] <= i_vert_x;
            r_v[1] <= i_vert_y;
            r_v[2] <= i_vert_z;
            r_last <= i_last_vertex;
        end
        // product consumption
        if (r_pvalid) begin
            case (r_ptag)
                ovbb_pkg::STEP_XX: r_q[0] <= r_prod[PW-1:0];
                ovbb_pkg::STEP_YY: r_q[1] <= r_prod[PW-1:0];
                ovbb_pkg::STEP_ZZ: r_q[2] <= r_prod[PW-1:0];
                ovbb_pkg::STEP_XY: r_q[3] <= r_prod[PW-1:0];
                ovbb_pkg::STEP_XZ: r_q[4] <= r_prod[PW-1:0];
                ovbb_pkg::STEP_YZ: r_q[5] <= r_prod[PW-1:0];
                ovbb_pkg::STEP_WX: r_q[6] <= r_prod[PW-1:0];
                ovbb_pkg::STEP_WY: r_q[7] <= r_prod[PW-1:0];
                ovbb_pkg::STEP_WZ: r_q[8] <= r_prod[PW-1:0];
                ovbb_pkg::STEP_M00, ovbb_pkg::STEP_M01, ovbb_pkg::STEP_M02:
                    r_acc[0] <= r_acc[0] + r_prod;
                ovbb_pkg::STEP_M10, ovbb_pkg::STEP_M11, ovbb_pkg::STEP_M12:
                    r_acc[1] <= r_acc[1] + r_prod;
                ovbb_pkg::STEP_M20, ovbb_pkg::STEP_M21, ovbb_pkg::STEP_M22:
                    r_acc[2] <= r_acc[2] + r_prod;
                ovbb_pkg::STEP_SX: r_t[0] <= ovbb_pkg::sat32(w_prod_rnd);
                ovbb_pkg::STEP_SY: r_t[1] <= ovbb_pkg::sat32(w_prod_rnd);
                ovbb_pkg::STEP_SZ: r_t[2] <= ovbb_pkg::sat32(w_prod_rnd);
                default: ;
            endcase
        end
        // step actions without a product
        if (i_cmd.run) begin
            case (i_cmd.step)
                ovbb_pkg::STEP_MATRIX: begin
                    for (int k = 0; k < 9; k++) r_m[k] <= w_m[k];
                    for (int k = 0; k < 3; k++) r_acc[k] <= '0;
                end
                ovbb_pkg::STEP_ROUND: begin
                    for (int k = 0; k < 3; k++) begin
                        r_r[k] <= ovbb_pkg::sat32((r_acc[k] + F_HALF) >>> FRAC_BITS);
                    end
                end
                default: ;
            endcase
        end
    end

    // bounds, cleared after a box
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_lo[k] <= '0;
                r_hi[k] <= '0;
            end
        end else if (i_cmd.finish && r_last) begin
            r_seen <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_lo[k] <= '0;
                r_hi[k] <= '0;
            end
        end else if (i_cmd.run && i_cmd.step == ovbb_pkg::STEP_BOUNDS) begin
            r_seen <= 1'b1;
            for (int k = 0; k < 3; k++) begin
                if (!r_seen || r_t[k] < r_lo[k]) r_lo[k] <= r_t[k];
                if (!r_seen || r_t[k] > r_hi[k]) r_hi[k] <= r_t[k];
            end
        end
    end

    // box output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && r_last) begin
            o_centre_x <= w_centre[0];
            o_centre_y <= w_centre[1];
            o_centre_z <= w_centre[2];
            o_half_x   <= w_half[0];
            o_half_y   <= w_half[1];
            o_half_z   <= w_half[2];
        end
    end

endmodule

>>> src/ovbb_checker.sv
// ----------------------------------------------------------------------------
// ovbb_checker
// Port-level checks of the bounding box, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ovbb_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  logic i_out_valid,
    input  logic i_out_ready
);

    // a box request stays up until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("box request dropped before taken");

    // a vertex keeps the block busy on the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("block ready right after a vertex");

    // a new box appears only at the end of vertex processing
    a_box_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("box raised while block was idle");

endmodule

bind oriented_vertex_bounding_box ovbb_checker u_ovbb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vert.valid),
    .i_in_ready  (i_vert.ready),
    .i_out_valid (o_box.valid),
    .i_out_ready (o_box.ready)
);
